>>> rtl/core/uarttx_pkg.sv
// Shared constants and codes for the UART transmit frame serializer.
// No dependencies; imported by uart_tx_frame_serializer.
package uarttx_pkg;

  // Byte buffer geometry
  localparam int BUF_DEPTH = 8;
  localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  // Frame shifter
  localparam int               FRAME_W    = 16;
  localparam logic [FRAME_W-1:0] FRAME_FILL = 16'hFFFF;
  localparam int               BITS_W     = 5;

  // Input item kinds carried on in_tuser
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ODD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BITS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT    = 3'd4;

  // Result payload width (four flags, padded to a byte)
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic rejected;
    logic busy_res;
    logic line_level;
    logic line_driven;
  } result_t;

endpackage

>>> rtl/core/uart_tx_frame_serializer.sv
// UART transmit frame serializer: byte buffer, frame builder and bit shifter.
// Depends on uarttx_pkg for buffer geometry, codes and the result type.
//
// Usage:
//   Input channel (in_*): each transaction is either a byte load (in_tuser =
//   load) or one bit-time tick (in_tuser = tick). A load queues in_tdata into
//   the byte buffer; in_tlast on a load closes the chunk and starts sending.
//   Loads while sending, or into a full buffer, are rejected.
//   While sending, each tick drives one frame bit LSB first, or builds the
//   next frame from the buffer (line not driven that tick), or, with the
//   chunk done, drives the line idle high and drops busy.
//   Result channel (out_*): exactly one result transaction per input
//   transaction, in order, carrying line_driven, line_level, busy and
//   rejected flags.
//   Config channel (cfg_*): always ready; write only while the block is idle.
// Timing:
//   One input transaction per clock while the skid stage is empty. Results are
//   registered into out_*, or parked in the skid stage. The byte buffer is a
//   synchronous RAM whose next-byte read is issued from the next-state
//   pointers, so a frame build always finds its byte already registered.
// Reset: clears counters, busy and config (8 data bits, 1 start, 1 stop, no
//   parity). Buffer contents stay undefined; only written entries are read.
// Stall: an output register plus a one-entry skid stage hold results; input
//   ready drops only once the skid stage is occupied.
module uart_tx_frame_serializer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] data_byte
  input  logic                               in_tuser,   // [0] func
  input  logic                               in_tlast,   // start_req
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] line_driven, [1] line_level, [2] busy_res, [3] rejected, [7:4] zero
  output logic [uarttx_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [uarttx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uarttx_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import uarttx_pkg::*;

  // Configuration registers
  logic       parity_enable_r;
  logic       parity_odd_r;
  logic [3:0] data_bits_r;
  logic [1:0] start_count_r;
  logic [1:0] stop_count_r;

  // Control state
  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic [CNT_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [BITS_W-1:0]  bits_left_r, bits_left_nxt;
  logic               sending_r, sending_nxt;

  // Byte buffer RAM
  logic [7:0]       byte_mem [BUF_DEPTH];
  logic [7:0]       rd_data_r;
  logic [CNT_W-1:0] rd_ptr_nxt;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  // Output register and skid stage
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t skid_res_r, skid_res_nxt;

  logic    in_accept;
  result_t res;

  // Frame build datapath
  logic [3:0]         nd;
  logic [1:0]         ns;
  logic [1:0]         np;
  logic [7:0]         byte_masked;
  logic               par_bit;
  logic [FRAME_W-1:0] frame_par;
  logic [FRAME_W-1:0] frame_data;
  logic [FRAME_W-1:0] frame_built;
  logic [BITS_W-1:0]  frame_len;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;

  // Saturate config fields into their legal ranges
  always_comb begin
    if (data_bits_r < 4'd5) begin
      nd = 4'd5;
    end else if (data_bits_r > 4'd8) begin
      nd = 4'd8;
    end else begin
      nd = data_bits_r;
    end
    ns = (start_count_r == 2'd0) ? 2'd1 : ((start_count_r == 2'd3) ? 2'd2 : start_count_r);
    np = (stop_count_r == 2'd0) ? 2'd1 : ((stop_count_r == 2'd3) ? 2'd2 : stop_count_r);
  end

  // Build start zeros, data LSB first, optional parity, then stop ones
  always_comb begin
    byte_masked = rd_data_r & 8'(8'hFF >> (4'd8 - nd));
    par_bit     = (^byte_masked) ^ parity_odd_r;
    frame_par   = parity_enable_r ? {FRAME_FILL[FRAME_W-2:0], par_bit} : FRAME_FILL;
    frame_data  = (frame_par << nd) | {{(FRAME_W-8){1'b0}}, byte_masked};
    frame_built = frame_data << ns;
    frame_len   = BITS_W'(ns) + BITS_W'(nd) + BITS_W'(parity_enable_r) + BITS_W'(np);
  end

  // Item processing
  always_comb begin
    loaded_nxt     = loaded_r;
    bytes_left_nxt = bytes_left_r;
    frame_nxt      = frame_r;
    bits_left_nxt  = bits_left_r;
    sending_nxt    = sending_r;
    wr_en          = 1'b0;
    wr_addr        = loaded_r[IDX_W-1:0];
    res            = '{rejected: 1'b0, busy_res: 1'b0, line_level: 1'b1, line_driven: 1'b0};

    if (in_accept) begin
      if (in_tuser == FUNC_LOAD) begin
        if (sending_r) begin
          res.rejected = 1'b1;
        end else begin
          if (loaded_r < CNT_W'(BUF_DEPTH)) begin
            wr_en      = 1'b1;
            loaded_nxt = loaded_r + 1'b1;
          end else begin
            res.rejected = 1'b1;
          end
          if (in_tlast) begin
            sending_nxt    = 1'b1;
            bytes_left_nxt = loaded_nxt;
            bits_left_nxt  = '0;
          end
        end
      end else if (sending_r) begin
        if (bits_left_r != '0) begin
          // shift out the next frame bit
          res.line_driven = 1'b1;
          res.line_level  = frame_r[0];
          frame_nxt       = {1'b0, frame_r[FRAME_W-1:1]};
          bits_left_nxt   = bits_left_r - 1'b1;
        end else if (bytes_left_r == '0) begin
          // chunk done: drive idle and empty the buffer
          res.line_driven = 1'b1;
          res.line_level  = 1'b1;
          sending_nxt     = 1'b0;
          loaded_nxt      = '0;
        end else begin
          bytes_left_nxt = bytes_left_r - 1'b1;
          frame_nxt      = frame_built;
          bits_left_nxt  = frame_len;
        end
      end
    end
    res.busy_res = sending_nxt;

    // Prefetch the byte the next frame build will need
    rd_ptr_nxt = loaded_nxt - bytes_left_nxt;
    rd_addr    = rd_ptr_nxt[IDX_W-1:0];
  end

  // Byte buffer: one write port, one registered read with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_mem[wr_addr] <= in_tdata;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= in_tdata;
    end else begin
      rd_data_r <= byte_mem[rd_addr];
    end
  end

  // Output register and skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = in_accept;
        out_res_nxt   = res;
      end
    end else if (in_accept) begin
      // receiver stalled: park the result
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-4){1'b0}}, out_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_enable_r <= 1'b0;
      parity_odd_r    <= 1'b0;
      data_bits_r     <= 4'd8;
      start_count_r   <= 2'd1;
      stop_count_r    <= 2'd1;
      loaded_r        <= '0;
      bytes_left_r    <= '0;
      frame_r         <= FRAME_FILL;
      bits_left_r     <= '0;
      sending_r       <= 1'b0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PARITY_ENABLE: parity_enable_r <= cfg_data[0];
          CFG_PARITY_ODD:    parity_odd_r    <= cfg_data[0];
          CFG_DATA_BITS:     data_bits_r     <= cfg_data[3:0];
          CFG_START_COUNT:   start_count_r   <= cfg_data[1:0];
          CFG_STOP_COUNT:    stop_count_r    <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
      loaded_r     <= loaded_nxt;
      bytes_left_r <= bytes_left_nxt;
      frame_r      <= frame_nxt;
      bits_left_r  <= bits_left_nxt;
      sending_r    <= sending_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Result payload holds without reset
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule
